@@ rtl/bzs_pkg.sv @@
// ----------------------------------------------------------------------------
// bzs_pkg
// shared types and constants for the cubic bezier subdivider
// ----------------------------------------------------------------------------
package bzs_pkg;

	localparam int BZS_COORD_BITS      = 24;
	localparam int BZS_PARAM_FRAC_BITS = 16;
	localparam int BZS_RESULTS         = 9;

	typedef enum logic [1:0] {
		KIND_FIRST   = 2'd0,
		KIND_SECOND  = 2'd1,
		KIND_TANGENT = 2'd2
	} bzs_kind_t;

endpackage

@@ rtl/bzs_lerp.sv @@
// ----------------------------------------------------------------------------
// bzs_lerp
// two-stage lerp lane: product (q-p)*t, then p plus the rounded product
// ----------------------------------------------------------------------------
module bzs_lerp #(
	parameter int CW = 24,
	parameter int PF = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] p,
	input  logic signed [CW-1:0] q,
	input  logic        [PF:0]   t,
	output logic signed [CW-1:0] r
);

	localparam int PW = CW + PF + 2;
	localparam logic signed [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (PF - 1);

	logic signed [CW:0]   diff;
	logic signed [PF+1:0] ts;
	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] rnd;
	logic signed [CW-1:0] p_s1;

	assign diff = {q[CW-1], q} - {p[CW-1], p};
	assign ts   = {1'b0, t};
	// round to nearest, ties toward +inf
	assign rnd  = (prod_s1 + HALF) >>> PF;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= diff * ts;
			p_s1    <= p;
			r       <= p_s1 + rnd[CW-1:0];
		end
	end

endmodule

@@ rtl/bzs_ser.sv @@
// ----------------------------------------------------------------------------
// bzs_ser
// result serializer: holds one item's nine results and sends one beat a cycle
// ----------------------------------------------------------------------------
module bzs_ser #(
	parameter int OW = 27
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic signed [OW-1:0] ld_x [bzs_pkg::BZS_RESULTS],
	input  logic signed [OW-1:0] ld_y [bzs_pkg::BZS_RESULTS],
	input  logic                 ld_straight,
	output logic                 free,
	output logic                 strobe,
	output bzs_pkg::bzs_kind_t   kind,
	output logic [1:0]           point_index,
	output logic signed [OW-1:0] out_x,
	output logic signed [OW-1:0] out_y,
	output logic                 out_straight,
	output logic                 last
);

	import bzs_pkg::*;

	localparam int CNT_W = $clog2(BZS_RESULTS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BZS_RESULTS - 1);

	logic signed [OW-1:0] sx_q [BZS_RESULTS];
	logic signed [OW-1:0] sy_q [BZS_RESULTS];
	logic [CNT_W-1:0]     cnt_q;
	logic                 active_q;
	logic                 straight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) active_q <= 1'b0;
		end
	end

	// shift line, head is the current beat
	always_ff @(posedge clk) begin
		if (load) begin
			sx_q       <= ld_x;
			sy_q       <= ld_y;
			straight_q <= ld_straight;
		end else if (active_q) begin
			for (int i = 0; i < BZS_RESULTS - 1; i++) begin
				sx_q[i] <= sx_q[i+1];
				sy_q[i] <= sy_q[i+1];
			end
		end
	end

	always_comb begin
		if (cnt_q == CNT_LAST) begin
			kind        = KIND_TANGENT;
			point_index = 2'd0;
		end else begin
			kind        = cnt_q[2] ? KIND_SECOND : KIND_FIRST;
			point_index = cnt_q[1:0];
		end
	end

	assign free         = !active_q || (cnt_q == CNT_LAST);
	assign strobe       = active_q;
	assign out_x        = sx_q[0];
	assign out_y        = sy_q[0];
	assign out_straight = straight_q;
	assign last         = (cnt_q == CNT_LAST);

endmodule

@@ rtl/cubic_bezier_subdivide.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_subdivide
// de casteljau split of a 2d cubic bezier at t, plus tangent 3*(e-d)
// ----------------------------------------------------------------------------
// an accepted item runs through stages s1 to s7, then loads the serializer with its nine results
// the single result port sets the item rate: the serializer takes a new item in its last beat or when idle
// the seven-stage lerp pipeline takes an item every cycle while it can drain
// busy rises when the last stage holds an item the serializer cannot take yet
// reset clears valid bits and the serializer; the receiver never stalls
module cubic_bezier_subdivide #(
	parameter int COORD_BITS      = bzs_pkg::BZS_COORD_BITS,
	parameter int PARAM_FRAC_BITS = bzs_pkg::BZS_PARAM_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] p0_x,
	input  logic signed [COORD_BITS-1:0] p0_y,
	input  logic signed [COORD_BITS-1:0] p1_x,
	input  logic signed [COORD_BITS-1:0] p1_y,
	input  logic signed [COORD_BITS-1:0] p2_x,
	input  logic signed [COORD_BITS-1:0] p2_y,
	input  logic signed [COORD_BITS-1:0] p3_x,
	input  logic signed [COORD_BITS-1:0] p3_y,
	input  logic [PARAM_FRAC_BITS:0]     split_param,
	input  logic                         straight,
	output logic                         strobe,
	output logic [1:0]                   kind,
	output logic [1:0]                   point_index,
	output logic signed [COORD_BITS+2:0] out_x,
	output logic signed [COORD_BITS+2:0] out_y,
	output logic                         out_straight,
	output logic                         last
);

	import bzs_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int PF = PARAM_FRAC_BITS;
	localparam int OW = COORD_BITS + 3;
	localparam logic [PF:0] T_ONE = {1'b1, {PF{1'b0}}};

	// axis 0 is x, axis 1 is y
	logic signed [CW-1:0] in0 [2], in1 [2], in2 [2], in3 [2];

	// pipeline valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic adv;
	logic ser_free, ser_load;

	// carried payload
	logic [PF:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic        st_s1, st_s2, st_s3, st_s4, st_s5, st_s6, st_s7;
	logic signed [CW-1:0] p0_s1 [2], p0_s2 [2], p0_s3 [2], p0_s4 [2], p0_s5 [2];
	logic signed [CW-1:0] p0_s6 [2], p0_s7 [2];
	logic signed [CW-1:0] p1_s1 [2], p2_s1 [2];
	logic signed [CW-1:0] p3_s1 [2], p3_s2 [2], p3_s3 [2], p3_s4 [2], p3_s5 [2];
	logic signed [CW-1:0] p3_s6 [2], p3_s7 [2];
	logic signed [CW-1:0] a_s3 [2], a_s4 [2], a_s5 [2], a_s6 [2], a_s7 [2];
	logic signed [CW-1:0] b_s3 [2];
	logic signed [CW-1:0] c_s3 [2], c_s4 [2], c_s5 [2], c_s6 [2], c_s7 [2];
	logic signed [CW-1:0] d_s5 [2], d_s6 [2], d_s7 [2];
	logic signed [CW-1:0] e_s5 [2], e_s6 [2], e_s7 [2];
	logic signed [CW-1:0] f_s7 [2];
	logic signed [CW:0]   ed_s6 [2];
	logic signed [OW-1:0] tan_s7 [2];

	// serializer load beat
	logic signed [OW-1:0] ld_x [BZS_RESULTS];
	logic signed [OW-1:0] ld_y [BZS_RESULTS];
	bzs_kind_t            ser_kind;

	assign in0[0] = p0_x;  assign in0[1] = p0_y;
	assign in1[0] = p1_x;  assign in1[1] = p1_y;
	assign in2[0] = p2_x;  assign in2[1] = p2_y;
	assign in3[0] = p3_x;  assign in3[1] = p3_y;

	// whole pipe moves together; it holds only while the last stage is blocked
	assign ser_load = v_s7 && ser_free;
	assign adv      = !v_s7 || ser_free;
	assign busy     = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// t above one saturates to one
			t_s1  <= (split_param > T_ONE) ? T_ONE : split_param;
			t_s2  <= t_s1;
			t_s3  <= t_s2;
			t_s4  <= t_s3;
			t_s5  <= t_s4;
			st_s1 <= straight;
			st_s2 <= st_s1;
			st_s3 <= st_s2;
			st_s4 <= st_s3;
			st_s5 <= st_s4;
			st_s6 <= st_s5;
			st_s7 <= st_s6;
			for (int ax = 0; ax < 2; ax++) begin
				p0_s1[ax]  <= in0[ax];
				p1_s1[ax]  <= in1[ax];
				p2_s1[ax]  <= in2[ax];
				p3_s1[ax]  <= in3[ax];
				p0_s2[ax]  <= p0_s1[ax];
				p0_s3[ax]  <= p0_s2[ax];
				p0_s4[ax]  <= p0_s3[ax];
				p0_s5[ax]  <= p0_s4[ax];
				p0_s6[ax]  <= p0_s5[ax];
				p0_s7[ax]  <= p0_s6[ax];
				p3_s2[ax]  <= p3_s1[ax];
				p3_s3[ax]  <= p3_s2[ax];
				p3_s4[ax]  <= p3_s3[ax];
				p3_s5[ax]  <= p3_s4[ax];
				p3_s6[ax]  <= p3_s5[ax];
				p3_s7[ax]  <= p3_s6[ax];
				a_s4[ax]   <= a_s3[ax];
				a_s5[ax]   <= a_s4[ax];
				a_s6[ax]   <= a_s5[ax];
				a_s7[ax]   <= a_s6[ax];
				c_s4[ax]   <= c_s3[ax];
				c_s5[ax]   <= c_s4[ax];
				c_s6[ax]   <= c_s5[ax];
				c_s7[ax]   <= c_s6[ax];
				d_s6[ax]   <= d_s5[ax];
				d_s7[ax]   <= d_s6[ax];
				e_s6[ax]   <= e_s5[ax];
				e_s7[ax]   <= e_s6[ax];
				// tangent: e-d, then times three by shift and add
				ed_s6[ax]  <= {e_s5[ax][CW-1], e_s5[ax]} - {d_s5[ax][CW-1], d_s5[ax]};
				tan_s7[ax] <= OW'(ed_s6[ax]) + (OW'(ed_s6[ax]) <<< 1);
			end
		end
	end

	// three lerp levels, each two stages deep
	for (genvar ax = 0; ax < 2; ax++) begin : g_axis
		// level one: a, b, c out at stage 3
		bzs_lerp #(.CW(CW), .PF(PF)) u_a (
			.clk(clk), .en(adv), .p(p0_s1[ax]), .q(p1_s1[ax]), .t(t_s1), .r(a_s3[ax])
		);
		bzs_lerp #(.CW(CW), .PF(PF)) u_b (
			.clk(clk), .en(adv), .p(p1_s1[ax]), .q(p2_s1[ax]), .t(t_s1), .r(b_s3[ax])
		);
		bzs_lerp #(.CW(CW), .PF(PF)) u_c (
			.clk(clk), .en(adv), .p(p2_s1[ax]), .q(p3_s1[ax]), .t(t_s1), .r(c_s3[ax])
		);
		// level two: d, e out at stage 5
		bzs_lerp #(.CW(CW), .PF(PF)) u_d (
			.clk(clk), .en(adv), .p(a_s3[ax]), .q(b_s3[ax]), .t(t_s3), .r(d_s5[ax])
		);
		bzs_lerp #(.CW(CW), .PF(PF)) u_e (
			.clk(clk), .en(adv), .p(b_s3[ax]), .q(c_s3[ax]), .t(t_s3), .r(e_s5[ax])
		);
		// level three: split point f out at stage 7
		bzs_lerp #(.CW(CW), .PF(PF)) u_f (
			.clk(clk), .en(adv), .p(d_s5[ax]), .q(e_s5[ax]), .t(t_s5), .r(f_s7[ax])
		);
	end

	// beat order: first half p0 a d f, second half f e c p3, then tangent
	assign ld_x[0] = OW'(p0_s7[0]);  assign ld_y[0] = OW'(p0_s7[1]);
	assign ld_x[1] = OW'(a_s7[0]);   assign ld_y[1] = OW'(a_s7[1]);
	assign ld_x[2] = OW'(d_s7[0]);   assign ld_y[2] = OW'(d_s7[1]);
	assign ld_x[3] = OW'(f_s7[0]);   assign ld_y[3] = OW'(f_s7[1]);
	assign ld_x[4] = OW'(f_s7[0]);   assign ld_y[4] = OW'(f_s7[1]);
	assign ld_x[5] = OW'(e_s7[0]);   assign ld_y[5] = OW'(e_s7[1]);
	assign ld_x[6] = OW'(c_s7[0]);   assign ld_y[6] = OW'(c_s7[1]);
	assign ld_x[7] = OW'(p3_s7[0]);  assign ld_y[7] = OW'(p3_s7[1]);
	assign ld_x[8] = tan_s7[0];      assign ld_y[8] = tan_s7[1];

	bzs_ser #(.OW(OW)) u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (ser_load),
		.ld_x         (ld_x),
		.ld_y         (ld_y),
		.ld_straight  (st_s7),
		.free         (ser_free),
		.strobe       (strobe),
		.kind         (ser_kind),
		.point_index  (point_index),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_straight (out_straight),
		.last         (last)
	);

	assign kind = ser_kind;

endmodule
